// ===== sv/wsre_pkg.sv =====
// Shared types and constants of the windowed sample rate estimator.
package wsre_pkg;

  localparam int RATE_W = 48;

  // One measurement word.
  typedef struct packed {
    logic [31:0] elapsed_ticks;
    logic [31:0] sample_count;
    logic [17:0] nominal_rate_hz;
  } meas_word_t;

  // One rate word.
  typedef struct packed {
    logic [47:0] rate_fraction;
    logic [1:0]  rate_source;
  } rate_word_t;

  // Codes of the rate_source field.
  localparam logic [1:0] SRC_STOPPED  = 2'd0;
  localparam logic [1:0] SRC_NOMINAL  = 2'd1;
  localparam logic [1:0] SRC_MEASURED = 2'd2;

  // Register index of the reference clock register and its reset value.
  localparam logic [0:0]  REG_REF_CLOCK   = 1'b0;
  localparam logic [31:0] REF_CLOCK_RESET = 32'd100000000;

  // Saturated value of the rate field.
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // Control of the bucket ring from the sequencer.
  typedef struct packed {
    logic clear;
    logic read;
    logic roll;
  } ring_ctrl_t;

endpackage

// ===== sv/wsre_divider.sv =====
// Restoring fractional divider that yields one quotient bit per cycle.
module wsre_divider #(
  parameter int FRACTION_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [31:0]               num,
  input  logic [31:0]               den,
  output logic                      done,
  output logic [wsre_pkg::RATE_W-1:0] quotient
);
  import wsre_pkg::*;

  localparam int STEPS = 32 + FRACTION_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [31:0]       num_sh;
  logic [31:0]       den_r;
  logic [31:0]       rem;
  logic [RATE_W-1:0] quo;
  logic              ovf;
  logic              busy;
  logic [CNT_W-1:0]  cnt;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    rem_sh = {rem, num_sh[31]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[33];
  end

  // Iteration registers; a quotient that outgrows the field saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(STEPS);
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
        quo    <= '0;
        ovf    <= (den == 32'd0);
      end else if (busy) begin
        num_sh <= {num_sh[30:0], 1'b0};
        rem    <= ge ? diff[31:0] : rem_sh[31:0];
        quo    <= {quo[RATE_W-2:0], ge};
        ovf    <= ovf | quo[RATE_W-1];
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = ovf ? RATE_MAX : quo;

endmodule

// ===== sv/wsre_ring.sv =====
// Ring of stored buckets with valid bits and running window totals.
module wsre_ring #(
  parameter int NUM_BUCKETS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsre_pkg::ring_ctrl_t ctrl,
  input  logic [31:0]          open_samples,
  input  logic [31:0]          open_ticks,
  output logic [31:0]          win_samples,
  output logic [31:0]          win_ticks
);
  import wsre_pkg::*;

  localparam int SLOT_W = $clog2(NUM_BUCKETS);

  logic [63:0]            mem [NUM_BUCKETS];
  logic [63:0]            rd_data;
  logic                   rd_valid;
  logic [SLOT_W-1:0]      slot;
  logic [NUM_BUCKETS-1:0] slot_valid;
  logic [31:0]            old_samples;
  logic [31:0]            old_ticks;

  // A slot never written since the last clear reads as zero.
  assign old_samples = rd_valid ? rd_data[63:32] : 32'd0;
  assign old_ticks   = rd_valid ? rd_data[31:0]  : 32'd0;

  // Bucket memory: read of the write slot ahead of a roll, then the write.
  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      rd_data <= mem[slot];
    end
    if (ctrl.roll) begin
      mem[slot] <= {open_samples, open_ticks};
    end
  end

  // Slot pointer, valid bits and totals; totals wrap modulo 2^32.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot        <= '0;
      slot_valid  <= '0;
      rd_valid    <= 1'b0;
      win_samples <= '0;
      win_ticks   <= '0;
    end else begin
      if (ctrl.read) begin
        rd_valid <= slot_valid[slot];
      end
      if (ctrl.roll) begin
        win_samples      <= win_samples - old_samples + open_samples;
        win_ticks        <= win_ticks - old_ticks + open_ticks;
        slot_valid[slot] <= 1'b1;
        if (slot == SLOT_W'(NUM_BUCKETS - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
    end
  end

endmodule

// ===== sv/windowed_sample_rate_estimator.sv =====
// Top level of the windowed sample rate estimator: sequencer, registers and ports.
//
// A measurement word (elapsed ticks, sample count, nominal rate) enters on the
// meas channel and one rate word leaves on the rate channel for each of them.
// The rate is samples per reference tick with FRACTION_BITS fraction bits in a
// 48-bit field, saturating at all ones. A stopped word (nominal rate zero) goes
// straight to the load state and into the output register. Every other word
// runs the shared divider, one quotient bit per cycle. A word answered from the
// nominal rate starts it at acceptance; a measured word first passes the sum
// state, which sums the window, and starts it there. meas_ready is high only
// while the sequencer is idle, so one item is in work at a time: a new
// measurement is taken only once the last one is loaded.
// The rate word sits in an output register; a stalled receiver keeps it there
// while the next measurement is accepted and worked on, and that result waits
// in the sequencer until the register frees up.
// A reset clears the bucket ring, the open bucket and the last nominal rate and
// sets the reference clock register to 100000000. No clearing pass is needed:
// valid bits mark the stored buckets. The APB port writes and reads the
// reference clock register at any address with paddr[2] low and is always ready.
module windowed_sample_rate_estimator #(
  parameter int NUM_BUCKETS      = 16,
  parameter int ITEMS_PER_BUCKET = 16,
  parameter int FRACTION_BITS    = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 meas_valid,
  output logic                 meas_ready,
  input  wsre_pkg::meas_word_t meas,
  output logic                 rate_valid,
  input  logic                 rate_ready,
  output wsre_pkg::rate_word_t rate,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import wsre_pkg::*;

  localparam int ITEM_W = $clog2(ITEMS_PER_BUCKET + 1);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_ROLL, S_DIV, S_LOAD} state_t;

  state_t            state;
  logic [31:0]       ref_clock;
  logic [17:0]       last_nominal;
  logic [31:0]       open_samples;
  logic [31:0]       open_ticks;
  logic [ITEM_W-1:0] open_items;
  logic [ITEM_W-1:0] open_items_next;
  logic              roll_pending;
  rate_word_t        res;

  logic              meas_accept;
  logic              stopped;
  logic              rate_change;
  logic              zero_ticks;
  ring_ctrl_t        ring_ctrl;
  logic [31:0]       win_samples;
  logic [31:0]       win_ticks;
  logic              div_start;
  logic [31:0]       div_num;
  logic [31:0]       div_den;
  logic              div_done;
  logic [RATE_W-1:0] div_quotient;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REF_CLOCK) ? ref_clock : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= REF_CLOCK_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_REF_CLOCK) begin
      ref_clock <= pwdata;
    end
  end

  // Decode of the incoming word.
  assign meas_ready      = (state == S_IDLE);
  assign meas_accept     = meas_valid && meas_ready;
  assign stopped         = (meas.nominal_rate_hz == 18'd0);
  assign rate_change     = (meas.nominal_rate_hz != last_nominal);
  assign zero_ticks      = (meas.elapsed_ticks == 32'd0);
  assign open_items_next = open_items + ITEM_W'(1);

  // Ring control: clear on a new nominal rate, fetch the slot ahead of a roll.
  assign ring_ctrl.clear = meas_accept && !stopped && rate_change;
  assign ring_ctrl.read  = meas_accept && !stopped && !rate_change && !zero_ticks;
  assign ring_ctrl.roll  = (state == S_ROLL);

  // Divider operands: nominal over reference clock, or window totals.
  assign div_start = (meas_accept && !stopped && (rate_change || zero_ticks)) ||
                     (state == S_SUM);
  assign div_num   = (state == S_SUM) ? open_samples + win_samples
                                      : {14'd0, meas.nominal_rate_hz};
  assign div_den   = (state == S_SUM) ? open_ticks + win_ticks : ref_clock;

  wsre_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (div_num),
    .den     (div_den),
    .done    (div_done),
    .quotient(div_quotient)
  );

  wsre_ring #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ring_ctrl),
    .open_samples(open_samples),
    .open_ticks  (open_ticks),
    .win_samples (win_samples),
    .win_ticks   (win_ticks)
  );

  // Sequencer with the open bucket and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rate_valid   <= 1'b0;
      last_nominal <= '0;
      open_samples <= '0;
      open_ticks   <= '0;
      open_items   <= '0;
      roll_pending <= 1'b0;
    end else begin
      // The output register empties when its word is taken and none replaces it.
      if (rate_valid && rate_ready && state != S_LOAD) begin
        rate_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (meas_accept) begin
            if (stopped) begin
              res.rate_fraction <= '0;
              res.rate_source   <= SRC_STOPPED;
              state             <= S_LOAD;
            end else if (rate_change) begin
              last_nominal    <= meas.nominal_rate_hz;
              open_samples    <= '0;
              open_ticks      <= '0;
              open_items      <= '0;
              roll_pending    <= 1'b0;
              res.rate_source <= SRC_NOMINAL;
              state           <= S_DIV;
            end else if (zero_ticks) begin
              res.rate_source <= SRC_NOMINAL;
              state           <= S_DIV;
            end else begin
              open_samples    <= open_samples + meas.sample_count;
              open_ticks      <= open_ticks + meas.elapsed_ticks;
              open_items      <= open_items_next;
              roll_pending    <= (open_items_next == ITEM_W'(ITEMS_PER_BUCKET));
              res.rate_source <= SRC_MEASURED;
              state           <= S_SUM;
            end
          end
        end
        S_SUM: begin
          state <= roll_pending ? S_ROLL : S_DIV;
        end
        S_ROLL: begin
          // The ring takes the open bucket in this cycle.
          open_samples <= '0;
          open_ticks   <= '0;
          open_items   <= '0;
          roll_pending <= 1'b0;
          state        <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res.rate_fraction <= div_quotient;
            state             <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!rate_valid || rate_ready) begin
            rate       <= res;
            rate_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
